// ----- sv/status_packet_deframer_macros.svh -----
// Assertion macros for the status packet deframer.
// Included by status_packet_deframer.sv, which checks its own logic; needs no other file.
`ifndef STATUS_PACKET_DEFRAMER_MACROS_SVH
`define STATUS_PACKET_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
// Checked while reset is released.
`define SPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define SPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/spd_pkg.sv -----
// Types and constants shared by the status packet deframer files.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

	localparam logic [7:0] HEADER_BYTE       = 8'hFF;
	localparam logic [7:0] MIN_LENGTH        = 8'd2;
	localparam logic [7:0] DEVICE_ID_RESET   = 8'd1;
	localparam logic [8:0] POS_ID            = 9'd2;
	localparam logic [8:0] POS_LENGTH        = 9'd3;
	localparam logic [8:0] POS_FIRST_PAYLOAD = 9'd4;

	// Frame tracking state carried from one byte to the next.
	typedef struct packed {
		logic [8:0] byte_count;
		logic [7:0] frame_length;
		logic [7:0] running_sum;
	} spd_state_t;

	// What is reported for one received byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [8:0] byte_position;
		logic       accepted;
		logic       frame_end;
		logic       checksum_ok;
	} spd_result_t;

endpackage

`default_nettype wire

// ----- sv/spd_step.sv -----
// Per-byte frame parser: next tracking state and the report for one byte.
// Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spd_step
	import spd_pkg::*;
(
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  device_id,
	input  wire spd_state_t  state,
	output spd_state_t       state_next,
	output spd_result_t      result
);

	logic [8:0] pos;
	logic [9:0] last_pos;
	logic       acc;
	logic       fend;
	logic       ok;

	assign pos = state.byte_count;
	// The checksum byte sits at position length + 3.
	assign last_pos = {2'b00, state.frame_length} + 10'd3;

	always_comb begin
		state_next = state;
		acc  = 1'b1;
		fend = 1'b0;
		ok   = 1'b0;
		if (pos < POS_ID) begin
			if (rx_byte == HEADER_BYTE) begin
				state_next.byte_count = pos + 9'd1;
			end else begin
				acc = 1'b0;
			end
		end else if (pos == POS_ID) begin
			if (rx_byte == device_id) begin
				state_next.running_sum = rx_byte;
				state_next.byte_count  = POS_LENGTH;
			end else begin
				acc = 1'b0;
			end
		end else if (pos == POS_LENGTH) begin
			// A length below two would leave no room for the info byte.
			if (rx_byte >= MIN_LENGTH) begin
				state_next.frame_length = rx_byte;
				state_next.running_sum  = state.running_sum + rx_byte;
				state_next.byte_count   = POS_FIRST_PAYLOAD;
			end else begin
				acc = 1'b0;
			end
		end else if ({1'b0, pos} >= last_pos) begin
			fend = 1'b1;
			ok   = (~state.running_sum == rx_byte);
			state_next.byte_count = '0;
		end else begin
			state_next.running_sum = state.running_sum + rx_byte;
			state_next.byte_count  = pos + 9'd1;
		end
		if (!acc) begin
			state_next.byte_count = '0;
		end
	end

	assign result.data_byte     = rx_byte;
	assign result.byte_position = pos;
	assign result.accepted      = acc;
	assign result.frame_end     = fend;
	assign result.checksum_ok   = ok;

endmodule

`default_nettype wire

// ----- sv/status_packet_deframer.sv -----
// Channel    Dir  tdata                          tuser                      tlast
// s_axis     in   [7:0] rx_byte                  -                          -
// m_axis     out  [7:0] data_byte, [16:8] pos    [0] accepted, [1] cksum ok frame_end
// device_id  in   write enable and 8-bit value, no read-back
//
// One byte per cycle sustained while m_axis takes results; a byte transferred
// on s_axis passes through the input register, then the parser logic into the
// result register, from which m_axis offers its report.
// Reset clears the frame tracking state and loads device id 1.
// While m_axis stalls the result register holds and the input register takes
// one more byte only if it is empty; the tracking state moves only when a byte
// enters the result register.
// Depends on spd_pkg, spd_step and status_packet_deframer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "status_packet_deframer_macros.svh"

module status_packet_deframer
	import spd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [16:8] byte_position, rest 0
	output logic [1:0]       m_axis_tuser,   // [0] accepted, [1] checksum_ok
	output logic             m_axis_tlast,   // frame_end
	input  wire logic        device_id_we,
	input  wire logic [7:0]  device_id_wdata
);

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        valid_s2;
	spd_result_t result_s2;
	spd_state_t  state_q;
	spd_state_t  state_d;
	spd_result_t result_d;
	logic [7:0]  device_id_q;
	logic        s1_ready;
	logic        s2_ready;
	logic        advance;

	assign s2_ready = !valid_s2 || m_axis_tready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign advance  = valid_s1 && s2_ready;
	assign s_axis_tready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= DEVICE_ID_RESET;
		end else if (device_id_we) begin
			device_id_q <= device_id_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && s_axis_tvalid) begin
			rx_byte_s1 <= s_axis_tdata;
		end
	end

	spd_step u_step (
		.rx_byte    (rx_byte_s1),
		.device_id  (device_id_q),
		.state      (state_q),
		.state_next (state_d),
		.result     (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				state_q <= state_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'b0, result_s2.byte_position, result_s2.data_byte};
	assign m_axis_tuser  = {result_s2.checksum_ok, result_s2.accepted};
	assign m_axis_tlast  = result_s2.frame_end;

	`SPD_ASSERT(a_count_range, clk, arst_n, state_q.byte_count <= 9'd258, "byte count past frame limit")
	`SPD_ASSERT(a_end_accepted, clk, arst_n, !(valid_s2 && m_axis_tlast) || m_axis_tuser[0], "frame end on a rejected byte")
	`SPD_ASSERT(a_ok_needs_end, clk, arst_n, !(valid_s2 && m_axis_tuser[1]) || m_axis_tlast, "checksum ok outside frame end")
	`SPD_ASSERT(a_end_restart, clk, arst_n, advance && result_d.frame_end |=> state_q.byte_count == 9'd0, "no restart after frame end")
	`SPD_ASSERT(a_reject_restart, clk, arst_n, advance && !result_d.accepted |=> state_q.byte_count == 9'd0, "no restart after rejected byte")

endmodule

`default_nettype wire

// ----- sim/status_packet_deframer_tb.sv -----
// Self-checking testbench for status_packet_deframer: streams received bytes in,
// predicts each byte's report and compares every result transfer against it.
// Depends on spd_pkg and the status_packet_deframer RTL.
`timescale 1ns / 1ps

module status_packet_deframer_tb;
	import spd_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 120;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_BYTES    = 260;

	// Tracks the frame state alongside the block and keeps the reports still owed.
	class frame_scoreboard;
		logic [7:0]  device_id;
		logic [8:0]  byte_count;
		logic [7:0]  frame_length;
		logic [7:0]  running_sum;
		spd_result_t pending_reports[$];
		int          errors;
		int          results_checked;
		int          frames_good;
		int          frames_bad;
		int          resyncs;
		int          deepest_position;

		function new();
			device_id        = DEVICE_ID_RESET;
			byte_count       = '0;
			frame_length     = '0;
			running_sum      = '0;
			errors           = 0;
			results_checked  = 0;
			frames_good      = 0;
			frames_bad       = 0;
			resyncs          = 0;
			deepest_position = 0;
		endfunction

		function void note_byte(logic [7:0] b);
			spd_result_t r;
			r.data_byte     = b;
			r.byte_position = byte_count;
			r.accepted      = 1'b1;
			r.frame_end     = 1'b0;
			r.checksum_ok   = 1'b0;
			if (byte_count < POS_ID) begin
				if (b == HEADER_BYTE)
					byte_count = byte_count + 9'd1;
				else
					r.accepted = 1'b0;
			end else if (byte_count == POS_ID) begin
				if (b == device_id) begin
					running_sum = b;
					byte_count  = POS_LENGTH;
				end else begin
					r.accepted = 1'b0;
				end
			end else if (byte_count == POS_LENGTH) begin
				if (b >= MIN_LENGTH) begin
					frame_length = b;
					running_sum  = running_sum + b;
					byte_count   = POS_FIRST_PAYLOAD;
				end else begin
					r.accepted = 1'b0;
				end
			end else if ({1'b0, byte_count} >= {2'b00, frame_length} + 10'd3) begin
				// The checksum byte closes the frame.
				r.frame_end   = 1'b1;
				r.checksum_ok = ((~running_sum) == b);
				byte_count    = '0;
			end else begin
				running_sum = running_sum + b;
				byte_count  = byte_count + 9'd1;
			end
			if (!r.accepted) begin
				byte_count = '0;
				resyncs++;
			end
			if (r.frame_end) begin
				if (r.checksum_ok)
					frames_good++;
				else
					frames_bad++;
			end
			if (int'(r.byte_position) > deepest_position)
				deepest_position = int'(r.byte_position);
			pending_reports.push_back(r);
		endfunction

		task report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
			errors++;
			// Keep the log readable if the block goes badly wrong.
			if (errors <= 100)
				$display("%0t ns MISMATCH %s: got %0h, expected %0h (result %0d)",
					$time, what, got, want, results_checked);
		endtask

		task check_result(input logic [23:0] tdata, input logic [1:0] tuser, input logic tlast);
			spd_result_t want;
			results_checked++;
			if (pending_reports.size() == 0) begin
				report_mismatch("result with nothing outstanding", tdata[15:0], 16'd0);
				return;
			end
			want = pending_reports.pop_front();
			if (tdata[7:0] !== want.data_byte)
				report_mismatch("data_byte", 16'(tdata[7:0]), 16'(want.data_byte));
			if (tdata[16:8] !== want.byte_position)
				report_mismatch("byte_position", 16'(tdata[16:8]), 16'(want.byte_position));
			if (tdata[23:17] !== '0)
				report_mismatch("tdata padding", 16'(tdata[23:17]), 16'd0);
			if (tuser[0] !== want.accepted)
				report_mismatch("accepted", 16'(tuser[0]), 16'(want.accepted));
			if (tuser[1] !== want.checksum_ok)
				report_mismatch("checksum_ok", 16'(tuser[1]), 16'(want.checksum_ok));
			if (tlast !== want.frame_end)
				report_mismatch("frame_end", 16'(tlast), 16'(want.frame_end));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;     // [7:0] data_byte, [16:8] byte_position, rest zero
	logic [1:0]  m_axis_tuser;     // [0] accepted, [1] checksum_ok
	logic        m_axis_tlast;     // frame_end
	logic        device_id_we;
	logic [7:0]  device_id_wdata;

	frame_scoreboard board = new();
	logic [7:0] current_id = DEVICE_ID_RESET;
	bit         no_idle = 1'b0;
	bit         hold_request = 1'b0;
	int         bytes_sent = 0;
	int         ids_used = 1;
	int         long_holds = 0;

	// Header and id errors, a short length, then a good minimum-size frame and a bad short one.
	logic [7:0] directed_bytes [23] = '{
		8'h00,
		HEADER_BYTE, 8'h7F,
		HEADER_BYTE, HEADER_BYTE, 8'h02,
		HEADER_BYTE, HEADER_BYTE, 8'h01, 8'h00,
		HEADER_BYTE, HEADER_BYTE, 8'h01, 8'h02, 8'h00, 8'hFC,
		HEADER_BYTE, HEADER_BYTE, 8'h01, 8'h03, 8'hFF, 8'hFF, 8'hFE
	};

	status_packet_deframer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.device_id_we    (device_id_we),
		.device_id_wdata (device_id_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly short frames; now and then a long one, rarely the longest.
	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 999);
		if (r < 3)
			return 8'd255;
		if (r < 20)
			return 8'($urandom_range(64, 254));
		return 8'($urandom_range(2, 12));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] cks;
		sum = id + len;
		send_byte(HEADER_BYTE);
		send_byte(HEADER_BYTE);
		send_byte(id);
		send_byte(len);
		// The info byte and the parameters make up len - 1 bytes.
		for (int i = 1; i < int'(len); i++) begin
			b   = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		cks = ~sum;
		if (corrupt)
			cks = cks ^ 8'($urandom_range(1, 255));
		send_byte(cks);
	endtask

	task automatic send_random_sequence();
		int kind;
		int n;
		logic [7:0] len;
		kind = $urandom_range(0, 99);
		len  = pick_length();
		if (kind < 65) begin
			send_frame(current_id, len, 1'b0);
		end else if (kind < 75) begin
			send_frame(current_id, len, 1'b1);
		end else if (kind < 82) begin
			// A frame cut short: the next bytes land in its payload.
			send_byte(HEADER_BYTE);
			send_byte(HEADER_BYTE);
			send_byte(current_id);
			send_byte(len);
			n = $urandom_range(0, 3);
			repeat (n) send_byte(8'($urandom));
		end else if (kind < 91) begin
			send_byte(HEADER_BYTE);
			case ($urandom_range(0, 2))
				0: begin
					send_byte(8'($urandom_range(0, 254)));
				end
				1: begin
					send_byte(HEADER_BYTE);
					send_byte(current_id ^ 8'($urandom_range(1, 255)));
				end
				default: begin
					send_byte(HEADER_BYTE);
					send_byte(current_id);
					send_byte(8'($urandom_range(0, 1)));
				end
			endcase
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(($urandom_range(0, 3) == 0) ? HEADER_BYTE : 8'($urandom));
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// The id register is only changed with nothing in flight.
	task automatic write_device_id(input logic [7:0] value);
		wait_drained();
		device_id_we    <= 1'b1;
		device_id_wdata <= value;
		@(posedge clk);
		device_id_we    <= 1'b0;
		board.device_id = value;
		current_id      = value;
		ids_used++;
	endtask

	initial begin : result_sink
		int stall_left;
		int r;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (hold_request) begin
				stall_left   = HOLD_CYCLES;
				hold_request = 1'b0;
				long_holds++;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8)
					stall_left = $urandom_range(1, 3);
				else if (r < 10)
					stall_left = $urandom_range(10, 40);
				m_axis_tready <= (stall_left == 0);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| device_id_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("status_packet_deframer regression: fail");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] id_plan [5];
		int phase_end;
		arst_n          <= 1'b0;
		s_axis_tvalid   <= 1'b0;
		s_axis_tdata    <= '0;
		device_id_we    <= 1'b0;
		device_id_wdata <= '0;
		id_plan[0] = 8'h00;
		id_plan[1] = 8'hFF;
		id_plan[2] = 8'($urandom);
		id_plan[3] = 8'($urandom);
		id_plan[4] = DEVICE_ID_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);

		foreach (id_plan[p]) begin
			write_device_id(id_plan[p]);
			if (p == 1) begin
				// Hold the output off as the longest frame starts to stream in.
				hold_request = 1'b1;
				send_frame(current_id, 8'd255, 1'b0);
			end
			if (p == 3)
				hold_request = 1'b1;
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				no_idle = ((bytes_sent / 100) % 4) == 3;
				send_random_sequence();
			end
			no_idle = 1'b0;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending_reports.size() != 0)
			board.report_mismatch("reports never delivered",
				16'(board.pending_reports.size()), 16'd0);

		$display("Sent %0d bytes under %0d device id settings; %0d resyncs, deepest position %0d.",
			bytes_sent, ids_used, board.resyncs, board.deepest_position);
		$display("Frames closed: %0d with a good checksum, %0d with a bad one; %0d long holds.",
			board.frames_good, board.frames_bad, long_holds);
		if (board.errors == 0)
			$display("status_packet_deframer regression: pass");
		else
			$display("status_packet_deframer regression: fail");
		$finish;
	end

endmodule
